// File: hw/rtl/fir_pkg.sv
// Package: shared widths, types and controller states for the FIR filter.
`default_nettype none

package fir_pkg;

  localparam int DATA_W       = 16;
  localparam int COEF_W       = 16;
  localparam int NUM_COEF     = 8;
  localparam int COEF_IW      = 3;
  localparam int PROD_W       = DATA_W + COEF_W;
  localparam int ACC_W        = PROD_W + COEF_IW;
  localparam int Q_FRAC       = 15;
  localparam int QUOT_W       = ACC_W - Q_FRAC;
  localparam int TAPS_DEFAULT = 8;
  localparam int APB_AW       = COEF_IW + 2;
  localparam int APB_DW       = 32;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DONE
  } fir_state_t;

  typedef struct packed {
    logic load;
    logic acc_clr;
    logic mac_en;
    logic out_load;
  } fir_cmd_t;

  typedef struct packed {
    logic will_fire;
    logic out_free;
  } fir_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/fir_cfg.sv
// APB coefficient register file for the FIR filter.
`default_nettype none

module fir_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fir_pkg::APB_AW-1:0] paddr,
  input  wire logic [fir_pkg::APB_DW-1:0] pwdata,
  output logic      [fir_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output fir_pkg::coef_arr_t              coefs
);

  logic [fir_pkg::COEF_IW-1:0] reg_idx;
  logic                        wr_en;

  assign reg_idx = paddr[fir_pkg::APB_AW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= '0;
    end else if (wr_en) begin
      coefs[reg_idx] <= pwdata[fir_pkg::COEF_W-1:0];
    end
  end

  always_comb begin
    prdata = fir_pkg::APB_DW'($signed(coefs[reg_idx]));
  end

endmodule

`default_nettype wire

// File: hw/rtl/fir_ctrl.sv
// Controller: sequences sample load, tap-by-tap multiply-accumulate and output.
`default_nettype none

module fir_ctrl #(
  parameter int TAPS  = fir_pkg::TAPS_DEFAULT,
  parameter int TAP_W = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  fir_pkg::fir_sts_t     sts,
  output fir_pkg::fir_cmd_t     cmd,
  output logic      [TAP_W-1:0] tap
);

  fir_pkg::fir_state_t state;
  fir_pkg::fir_state_t state_next;
  logic                accept;
  logic                last_tap;

  assign accept   = s_axis_tvalid & (state == fir_pkg::ST_IDLE);
  assign last_tap = (tap == TAP_W'(TAPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fir_pkg::ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      if (state == fir_pkg::ST_MAC) begin
        tap <= tap + TAP_W'(1);
      end else begin
        tap <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fir_pkg::ST_IDLE: begin
        if (accept && sts.will_fire) begin
          state_next = fir_pkg::ST_MAC;
        end
      end
      fir_pkg::ST_MAC: begin
        if (last_tap) begin
          state_next = fir_pkg::ST_DONE;
        end
      end
      fir_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = fir_pkg::ST_IDLE;
        end
      end
      default: state_next = fir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      fir_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = accept;
        cmd.acc_clr   = accept;
      end
      fir_pkg::ST_MAC: begin
        cmd.mac_en = 1'b1;
      end
      fir_pkg::ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/fir_datapath.sv
// Datapath: delay line, fill counter, shared MAC, rounding, saturation, output register.
`default_nettype none

module fir_datapath #(
  parameter int TAPS  = fir_pkg::TAPS_DEFAULT,
  parameter int TAP_W = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [fir_pkg::DATA_W-1:0] s_axis_tdata,
  output logic      [fir_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  input  fir_pkg::coef_arr_t              coefs,
  input  fir_pkg::fir_cmd_t               cmd,
  input  wire logic [TAP_W-1:0]           tap,
  output fir_pkg::fir_sts_t               sts
);

  localparam int FILL_W = $clog2(TAPS + 1);

  localparam logic signed [fir_pkg::QUOT_W-1:0] SAT_HI = fir_pkg::QUOT_W'(32767);
  localparam logic signed [fir_pkg::QUOT_W-1:0] SAT_LO = -fir_pkg::QUOT_W'(32768);

  logic        [fir_pkg::DATA_W-1:0] line [TAPS];
  logic        [FILL_W-1:0]          fill_count;
  logic signed [fir_pkg::ACC_W-1:0]  acc;
  logic signed [fir_pkg::PROD_W-1:0] prod;
  logic signed [fir_pkg::QUOT_W-1:0] quot;
  logic signed [fir_pkg::QUOT_W-1:0] quot_rnd;
  logic        [fir_pkg::DATA_W-1:0] sat;

  assign sts.will_fire = (fill_count >= FILL_W'(TAPS - 1));
  assign sts.out_free  = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line[0] <= s_axis_tdata;
      for (int i = 1; i < TAPS; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.load && (fill_count != FILL_W'(TAPS))) begin
      fill_count <= fill_count + FILL_W'(1);
    end
  end

  always_comb begin
    prod = $signed(coefs[fir_pkg::COEF_IW'(tap)]) * $signed(line[tap]);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.mac_en) begin
      acc <= acc + fir_pkg::ACC_W'(prod);
    end
  end

  always_comb begin
    quot = acc[fir_pkg::ACC_W-1:fir_pkg::Q_FRAC];
    if (acc[fir_pkg::ACC_W-1] && (acc[fir_pkg::Q_FRAC-1:0] != '0)) begin
      quot_rnd = quot + fir_pkg::QUOT_W'(1);
    end else begin
      quot_rnd = quot;
    end
    if (quot_rnd > SAT_HI) begin
      sat = SAT_HI[fir_pkg::DATA_W-1:0];
    end else if (quot_rnd < SAT_LO) begin
      sat = SAT_LO[fir_pkg::DATA_W-1:0];
    end else begin
      sat = quot_rnd[fir_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= sat;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fir_filter_pcm16.sv
// After the item that completes a result is accepted, the shared MAC steps through every
// tap; no new item is accepted until its result is loaded into the output register.
// The output register holds a result while the next item is accepted and shifted in.
// No result until TAPS items have arrived since reset.
// Synchronous active-high reset clears control state, fill count and coefficients.
`default_nettype none

module fir_filter_pcm16 #(
  parameter int TAPS = fir_pkg::TAPS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [fir_pkg::DATA_W-1:0] s_axis_tdata,   // [15:0] sample_in
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [fir_pkg::DATA_W-1:0] m_axis_tdata,   // [15:0] sample_out
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [fir_pkg::APB_AW-1:0] paddr,
  input  wire logic [fir_pkg::APB_DW-1:0] pwdata,
  output logic      [fir_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);

  localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  fir_pkg::coef_arr_t coefs;
  fir_pkg::fir_cmd_t  cmd;
  fir_pkg::fir_sts_t  sts;
  logic [TAP_W-1:0]   tap;

  fir_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  fir_ctrl #(
    .TAPS  (TAPS),
    .TAP_W (TAP_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd),
    .tap           (tap)
  );

  fir_datapath #(
    .TAPS  (TAPS),
    .TAP_W (TAP_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .coefs         (coefs),
    .cmd           (cmd),
    .tap           (tap),
    .sts           (sts)
  );

endmodule

`default_nettype wire

// File: bench/fir_filter_pcm16_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the PCM16 FIR filter: predicts each output item from the inputs and coefficients.

class fir_output_tracker;
  logic signed [fir_pkg::COEF_W-1:0] coef [fir_pkg::NUM_COEF];
  logic signed [fir_pkg::DATA_W-1:0] history [fir_pkg::NUM_COEF];
  int unsigned filled;
  logic [fir_pkg::DATA_W-1:0] expected_out [$];
  int mismatches;
  int checked;
  int clipped;

  function new();
    foreach (coef[i]) begin
      coef[i] = '0;
      history[i] = '0;
    end
    filled = 0;
    mismatches = 0;
    checked = 0;
    clipped = 0;
  endfunction

  function void load_coef(input int idx, input logic [fir_pkg::COEF_W-1:0] value);
    if (idx < fir_pkg::NUM_COEF) begin
      coef[idx] = value;
    end
  endfunction

  function logic [fir_pkg::DATA_W-1:0] filtered_value();
    longint acc;
    longint y;
    int k;
    acc = 0;
    for (k = 0; k < fir_pkg::TAPS_DEFAULT; k++) begin
      acc += longint'(coef[k]) * longint'(history[k]);
    end
    // truncate toward zero, then clip to 16 bits
    y = acc / 32768;
    if (y > 32767) begin
      y = 32767;
      clipped++;
    end else if (y < -32768) begin
      y = -32768;
      clipped++;
    end
    return y[fir_pkg::DATA_W-1:0];
  endfunction

  function void add_sample(input logic [fir_pkg::DATA_W-1:0] x);
    int k;
    for (k = fir_pkg::NUM_COEF - 1; k > 0; k--) begin
      history[k] = history[k-1];
    end
    history[0] = x;
    if (filled < fir_pkg::TAPS_DEFAULT) begin
      filled++;
    end
    if (filled >= fir_pkg::TAPS_DEFAULT) begin
      expected_out.push_back(filtered_value());
    end
  endfunction

  function void check_output(input logic [fir_pkg::DATA_W-1:0] y);
    logic [fir_pkg::DATA_W-1:0] want;
    checked++;
    if (expected_out.size() == 0) begin
      mismatches++;
      $error("sample_out: no item expected, actual %0d", $signed(y));
    end else begin
      want = expected_out.pop_front();
      if (y !== want) begin
        mismatches++;
        $error("sample_out mismatch: expected %0d, actual %0d", $signed(want), $signed(y));
      end
    end
  endfunction
endclass

module fir_filter_pcm16_tb;

  localparam int CLK_PERIOD = 10;
  localparam int TAPS       = fir_pkg::TAPS_DEFAULT;
  localparam int LATENCY    = TAPS + 2;
  localparam int REG_STRIDE = 4;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 72;

  localparam logic [15:0] PCM_MAX = 16'h7FFF;
  localparam logic [15:0] PCM_MIN = 16'h8000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [fir_pkg::DATA_W-1:0] s_axis_tdata;   // [15:0] sample_in
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [fir_pkg::DATA_W-1:0] m_axis_tdata;   // [15:0] sample_out
  logic psel;
  logic penable;
  logic pwrite;
  logic [fir_pkg::APB_AW-1:0] paddr;
  logic [fir_pkg::APB_DW-1:0] pwdata;
  logic [fir_pkg::APB_DW-1:0] prdata;
  logic pready;

  fir_output_tracker sb;
  logic [15:0] ready_pattern = 16'hFFFF;
  int ready_pos = 0;
  int idle_cycles = 0;
  int items_in = 0;
  int settings = 0;
  int fails = 0;
  bit busy;

  fir_filter_pcm16 uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready = ready_pattern[ready_pos];
    ready_pos = (ready_pos + 1) % 16;
  end

  always @(posedge clk) begin
    if (!rst) begin
      busy = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata);
        busy = 1'b1;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.add_sample(s_axis_tdata);
        items_in++;
        busy = 1'b1;
      end
      if (psel && penable && pready) begin
        busy = 1'b1;
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("fir_filter_pcm16_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic write_coef(input int idx, input logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = fir_pkg::APB_AW'(idx * REG_STRIDE);
    pwdata = {{16{value[15]}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.load_coef(idx, value);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== value) begin
      fails++;
      $error("coef_%0d readback mismatch: expected %0d, actual %0d",
             idx, $signed(value), $signed(prdata[15:0]));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] x, input bit keep_valid);
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = x;
    do @(posedge clk); while (!s_axis_tready);
    if (!keep_valid) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
  endtask

  task automatic drain();
    while (sb.expected_out.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(9, 0))
      0: return PCM_MIN;
      1: return PCM_MAX;
      2: return 16'($urandom_range(8, 0)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_coef(input int kind);
    case (kind)
      0: return PCM_MAX;
      2: return 16'($urandom_range(8191, 0)) - 16'd4096;
      3: begin
        if ($urandom_range(3, 0) != 0) return 16'h0000;
        return $urandom_range(1, 0) ? PCM_MIN : PCM_MAX;
      end
      4: begin
        case ($urandom_range(3, 0))
          0: return 16'h0000;
          1: return PCM_MIN;
          2: return PCM_MAX;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count, input int gap_max);
    int left;
    int burst;
    int gap;
    bit keep;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(8, 1);
      while (burst > 0 && left > 0) begin
        burst--;
        left--;
        gap = (burst == 0) ? $urandom_range(gap_max, 0) : 0;
        keep = (gap == 0) && (left > 0);
        send_sample(random_sample(), keep);
        if (gap > 1) repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  initial begin
    int i;
    int phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    sb = new();
    repeat (6) @(negedge clk);
    rst = 0;

    // all taps at -1.0: fill, then clip high and low
    for (i = 0; i < fir_pkg::NUM_COEF; i++) write_coef(i, PCM_MIN);
    settings++;
    repeat (8) send_sample(PCM_MIN, 1'b1);
    repeat (6) send_sample(PCM_MAX, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    drain();

    // single half-gain tap: negative halves round toward zero
    ready_pattern = 16'hA5A5;
    write_coef(0, 16'h4000);
    for (i = 1; i < fir_pkg::NUM_COEF; i++) write_coef(i, 16'h0000);
    settings++;
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFD, 1'b1);
    send_sample(16'h0003, 1'b1);
    send_sample(PCM_MIN, 1'b1);
    send_sample(PCM_MAX, 1'b0);
    drain();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      for (i = 0; i < fir_pkg::NUM_COEF; i++) write_coef(i, pick_coef(phase % 5));
      settings++;
      if (phase == 0) ready_pattern = 16'hFFFF;
      else if (phase == 3) ready_pattern = 16'h0007;
      else ready_pattern = 16'($urandom) | 16'h0001;
      send_random(PHASE_ITEMS, (phase % 3 == 0) ? 0 : ((phase % 2 != 0) ? 12 : 3));
      drain();
    end

    if (sb.expected_out.size() != 0) begin
      fails++;
      $error("sample_out: %0d expected items never arrived", sb.expected_out.size());
    end
    $display("Run covered %0d input items and %0d filtered outputs under %0d coefficient sets,",
             items_in, sb.checked, settings);
    $display("with %0d outputs clipped to the 16-bit range.", sb.clipped);
    if (fails + sb.mismatches == 0) begin
      $display("fir_filter_pcm16_tb: PASS");
    end else begin
      $display("fir_filter_pcm16_tb: FAIL");
    end
    $finish;
  end

endmodule
